// ===== design/bdib_pkg.sv =====
// Shared constants, codes and types of the block diff instruction builder.
`default_nettype none
package bdib_pkg;

   localparam int TABLE_ENTRIES = 4096;
   localparam int MAX_APPEND    = 256;
   localparam int MAX_COPY      = 65535;

   localparam int TABLE_AW = $clog2(TABLE_ENTRIES);
   localparam int FILL_W   = $clog2(TABLE_ENTRIES + 1);
   localparam int DIG_W    = 64;
   localparam int IDX_W    = 32;
   localparam int CNT_W    = 16;

   localparam logic [IDX_W-1:0] ALL_ONES = 32'hffff_ffff;

   localparam logic [1:0] CMD_LOAD   = 2'd0;
   localparam logic [1:0] CMD_LOOKUP = 2'd1;
   localparam logic [1:0] CMD_FINISH = 2'd2;

   typedef struct packed {
      logic [DIG_W-1:0] digest_hi;
      logic [DIG_W-1:0] digest_lo;
      logic [IDX_W-1:0] block_index;
   } entry_type;

   typedef struct packed {
      logic [IDX_W-1:0] seek_to;
      logic [CNT_W-1:0] copy_count;
      logic [CNT_W-1:0] append_count;
      logic             end_marker;
      logic             last;
   } result_type;

endpackage
`default_nettype wire

// ===== design/block_diff_instruction_builder.sv =====
// Top level of the block diff instruction builder: search sequencer, run tracker, result queue.
//
//   channel  dir  handshake            word
//   req      in   req_valid/req_stall  cmd, digest, entry block index
//   rsp      out  rsp_valid/rsp_stall  seek, copy count, append count, end marker, last
//
// A load fills the next table slot unless the table is full. A lookup ends its search early when
// a probe hits: every binary search probe is one table read plus one compare on the read data.
// Finish queues any open run, then the end marker. Reset is synchronous; the table is not cleared.
// Results sit in a two-word queue, so the next item is taken while results wait;
// a new item's results wait in the run stage until the queue has drained.
`default_nettype none
module block_diff_instruction_builder
   import bdib_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output      logic             req_stall,
   input  wire logic [1:0]       req_cmd,
   input  wire logic [DIG_W-1:0] req_digest_hi,
   input  wire logic [DIG_W-1:0] req_digest_lo,
   input  wire logic [IDX_W-1:0] req_entry_block_index,
   output      logic             rsp_valid,
   input  wire logic             rsp_stall,
   output      logic [IDX_W-1:0] rsp_seek_to,
   output      logic [CNT_W-1:0] rsp_copy_count,
   output      logic [CNT_W-1:0] rsp_append_count,
   output      logic             rsp_end_marker,
   output      logic             rsp_last
);

   typedef enum logic [5:0] {
      S_IDLE   = 6'b000001,
      S_SEARCH = 6'b000010,
      S_PROBE  = 6'b000100,
      S_CHKA   = 6'b001000,
      S_CHKB   = 6'b010000,
      S_RUN    = 6'b100000
   } state_type;

   localparam logic [CNT_W-1:0] MAX_COPY_C   = CNT_W'(MAX_COPY);
   localparam logic [CNT_W-1:0] MAX_APPEND_C = CNT_W'(MAX_APPEND);
   localparam logic [FILL_W-1:0] FULL_C      = FILL_W'(TABLE_ENTRIES);

   state_type         state_ff, state_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [FILL_W-1:0] lo_ff, lo_in;
   logic [FILL_W-1:0] hi_ff, hi_in;
   logic [FILL_W-1:0] p_ff, p_in;
   logic [DIG_W-1:0]  key_hi_ff, key_hi_in;
   logic [DIG_W-1:0]  key_lo_ff, key_lo_in;
   logic              finish_ff, finish_in;
   logic              hit_ff, hit_in;
   logic [IDX_W-1:0]  found_ff, found_in;
   logic [IDX_W-1:0]  wanted_ff, wanted_in;
   logic [IDX_W-1:0]  start_ff, start_in;
   logic [CNT_W-1:0]  copies_ff, copies_in;
   logic [CNT_W-1:0]  appends_ff, appends_in;
   result_type        q_ff [2];
   logic [1:0]        q_cnt_ff;

   logic                wr_en;
   entry_type           wr_data;
   logic [TABLE_AW-1:0] rd_addr;
   entry_type           rd_data;

   logic              accept;
   logic              pop;
   logic              commit;
   logic              ent_eq;
   logic              ent_lt;
   logic [FILL_W-1:0] mid;
   logic [FILL_W-1:0] lo_m1;
   result_type        r0;
   result_type        r1;
   logic [1:0]        r_cnt;
   logic              run_busy;
   logic              flush0;
   logic              new_run;
   logic [CNT_W-1:0]  c_next;
   logic [CNT_W-1:0]  a_next;
   result_type        run_rec;
   result_type        end_rec;

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = (q_cnt_ff != 2'd0);
   assign pop       = rsp_valid && !rsp_stall;
   assign commit    = (state_ff == S_RUN) && (q_cnt_ff == 2'd0);

   assign rsp_seek_to      = q_ff[0].seek_to;
   assign rsp_copy_count   = q_ff[0].copy_count;
   assign rsp_append_count = q_ff[0].append_count;
   assign rsp_end_marker   = q_ff[0].end_marker;
   assign rsp_last         = q_ff[0].last;

   assign wr_en   = accept && (req_cmd == CMD_LOAD) && (fill_ff < FULL_C);
   assign wr_data = '{digest_hi: req_digest_hi, digest_lo: req_digest_lo,
                      block_index: req_entry_block_index};

   bdib_table u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (fill_ff[TABLE_AW-1:0]),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign ent_eq = (rd_data.digest_hi == key_hi_ff) && (rd_data.digest_lo == key_lo_ff);
   assign ent_lt = (rd_data.digest_hi < key_hi_ff) ||
                   ((rd_data.digest_hi == key_hi_ff) && (rd_data.digest_lo < key_lo_ff));
   assign mid    = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign lo_m1  = lo_ff - FILL_W'(1);

   // search sequencer
   always_comb begin
      state_in  = state_ff;
      fill_in   = fill_ff;
      lo_in     = lo_ff;
      hi_in     = hi_ff;
      p_in      = p_ff;
      key_hi_in = key_hi_ff;
      key_lo_in = key_lo_ff;
      finish_in = finish_ff;
      hit_in    = hit_ff;
      found_in  = found_ff;
      wanted_in = wanted_ff;
      rd_addr   = mid[TABLE_AW-1:0];
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (req_cmd)
                  CMD_LOAD: begin
                     if (fill_ff < FULL_C) begin
                        fill_in = fill_ff + FILL_W'(1);
                     end
                  end
                  CMD_LOOKUP: begin
                     lo_in     = '0;
                     hi_in     = fill_ff;
                     key_hi_in = req_digest_hi;
                     key_lo_in = req_digest_lo;
                     finish_in = 1'b0;
                     hit_in    = 1'b0;
                     state_in  = S_SEARCH;
                  end
                  CMD_FINISH: begin
                     finish_in = 1'b1;
                     state_in  = S_RUN;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_SEARCH: begin
            if (lo_ff < hi_ff) begin
               rd_addr  = mid[TABLE_AW-1:0];
               p_in     = mid;
               state_in = S_PROBE;
            end else if (lo_ff < fill_ff) begin
               rd_addr  = lo_ff[TABLE_AW-1:0];
               state_in = S_CHKA;
            end else if (lo_ff != '0) begin
               rd_addr  = lo_m1[TABLE_AW-1:0];
               state_in = S_CHKB;
            end else begin
               state_in = S_RUN;
            end
         end
         S_PROBE: begin
            if (ent_eq && (rd_data.block_index == wanted_ff)) begin
               hit_in    = 1'b1;
               found_in  = rd_data.block_index;
               wanted_in = rd_data.block_index + IDX_W'(1);
               state_in  = S_RUN;
            end else begin
               if (ent_lt || (ent_eq && (rd_data.block_index < wanted_ff))) begin
                  lo_in = p_ff + FILL_W'(1);
               end else begin
                  hi_in = p_ff;
               end
               state_in = S_SEARCH;
            end
         end
         S_CHKA: begin
            if (ent_eq) begin
               hit_in    = 1'b1;
               found_in  = rd_data.block_index;
               wanted_in = rd_data.block_index + IDX_W'(1);
               state_in  = S_RUN;
            end else if (lo_ff != '0) begin
               rd_addr  = lo_m1[TABLE_AW-1:0];
               state_in = S_CHKB;
            end else begin
               state_in = S_RUN;
            end
         end
         S_CHKB: begin
            if (ent_eq) begin
               hit_in    = 1'b1;
               found_in  = rd_data.block_index;
               wanted_in = rd_data.block_index + IDX_W'(1);
            end
            state_in = S_RUN;
         end
         S_RUN: begin
            if (commit) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // run tracker
   always_comb begin
      run_busy = (copies_ff != '0) || (appends_ff != '0);
      run_rec  = '{seek_to: start_ff, copy_count: copies_ff, append_count: appends_ff,
                   end_marker: 1'b0, last: 1'b0};
      end_rec  = '{seek_to: ALL_ONES, copy_count: '1, append_count: '1,
                   end_marker: 1'b1, last: 1'b1};
      flush0     = 1'b0;
      new_run    = 1'b0;
      c_next     = copies_ff + CNT_W'(1);
      a_next     = appends_ff + CNT_W'(1);
      r0         = end_rec;
      r1         = end_rec;
      r_cnt      = 2'd0;
      start_in   = start_ff;
      copies_in  = copies_ff;
      appends_in = appends_ff;
      if (finish_ff) begin
         if (run_busy) begin
            r0    = run_rec;
            r_cnt = 2'd2;
         end else begin
            r_cnt = 2'd1;
         end
         start_in   = ALL_ONES;
         copies_in  = '0;
         appends_in = '0;
      end else if (hit_ff) begin
         flush0  = run_busy &&
                   ((appends_ff != '0) ||
                    (found_ff != (start_ff + IDX_W'(copies_ff))));
         new_run = flush0 || (copies_ff == '0);
         if (new_run) begin
            c_next = CNT_W'(1);
         end
         if (flush0) begin
            r0      = run_rec;
            r0.last = 1'b1;
            r_cnt   = 2'd1;
         end
         start_in   = new_run ? found_ff : start_ff;
         copies_in  = c_next;
         appends_in = '0;
         if (c_next >= MAX_COPY_C) begin
            r0 = '{seek_to: start_ff, copy_count: c_next, append_count: '0,
                   end_marker: 1'b0, last: 1'b1};
            r_cnt      = 2'd1;
            start_in   = ALL_ONES;
            copies_in  = '0;
         end
      end else begin
         appends_in = a_next;
         if (a_next >= MAX_APPEND_C) begin
            r0 = '{seek_to: start_ff, copy_count: copies_ff, append_count: a_next,
                   end_marker: 1'b0, last: 1'b1};
            r_cnt      = 2'd1;
            start_in   = ALL_ONES;
            copies_in  = '0;
            appends_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         fill_ff    <= '0;
         wanted_ff  <= '0;
         start_ff   <= ALL_ONES;
         copies_ff  <= '0;
         appends_ff <= '0;
         q_cnt_ff   <= 2'd0;
      end else begin
         state_ff  <= state_in;
         fill_ff   <= fill_in;
         wanted_ff <= wanted_in;
         if (commit) begin
            start_ff   <= start_in;
            copies_ff  <= copies_in;
            appends_ff <= appends_in;
            q_cnt_ff   <= r_cnt;
         end else if (pop) begin
            q_cnt_ff <= q_cnt_ff - 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      lo_ff     <= lo_in;
      hi_ff     <= hi_in;
      p_ff      <= p_in;
      key_hi_ff <= key_hi_in;
      key_lo_ff <= key_lo_in;
      finish_ff <= finish_in;
      hit_ff    <= hit_in;
      found_ff  <= found_in;
      if (commit) begin
         q_ff[0] <= r0;
         q_ff[1] <= r1;
      end else if (pop) begin
         q_ff[0] <= q_ff[1];
      end
   end

   a_probe_in_table: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_PROBE) |-> (p_ff < fill_ff))
      else $error("probe address beyond table fill");

   a_search_bounds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SEARCH) |-> ((lo_ff <= hi_ff) && (hi_ff <= fill_ff)))
      else $error("search bounds out of order");

   a_fill_limit: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FULL_C)
      else $error("table fill beyond capacity");

   a_queue_depth: assert property (@(posedge clock) disable iff (reset)
      q_cnt_ff != 2'd3)
      else $error("result queue overflow");

   a_end_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_end_marker) |-> rsp_last)
      else $error("end marker not last word");

   a_no_empty_run: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_end_marker) |-> ((rsp_copy_count != '0) || (rsp_append_count != '0)))
      else $error("empty instruction emitted");

endmodule
`default_nettype wire

// ===== design/bdib_table.sv =====
// Old-file block table: one write port, one registered read port.
`default_nettype none
module bdib_table
   import bdib_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                wr_en,
   input  wire logic [TABLE_AW-1:0] wr_addr,
   input  wire entry_type           wr_data,
   input  wire logic [TABLE_AW-1:0] rd_addr,
   output      entry_type           rd_data
);

   entry_type mem [TABLE_ENTRIES];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data <= mem[rd_addr];
   end

endmodule
`default_nettype wire
